FILE: src/sesf_pkg.sv
// shared constants and types for the soft end stop force block
package sesf_pkg;

    localparam int DIV_W      = 38;
    localparam int DVSR_W     = 13;
    localparam int DIV_CNT_W  = $clog2(DIV_W);
    localparam int MUL_A_W    = 38;
    localparam int MUL_B_W    = 13;
    localparam int MUL_CNT_W  = $clog2(MUL_B_W);
    localparam int PEN_W      = 13;
    localparam int RAMP_W     = 7;
    localparam int LIMIT_W    = 30;
    localparam int BND_W      = 31;
    localparam int ADDR_W     = 3;

    localparam logic [BND_W-1:0]  ONSET_MARGIN        = 31'd1000;
    localparam logic [DVSR_W-1:0] FULL_FORCE_SPAN     = 13'd6577;
    localparam logic [DVSR_W-1:0] PERCENT_DIVISOR     = 13'd100;
    localparam logic [31:0]       RAMP_INTERVAL_MS    = 32'd50;
    localparam logic signed [31:0] RAMP_RESET_DISTANCE = 32'sd494;
    localparam logic [RAMP_W-1:0] RAMP_MAXIMUM        = 7'd100;
    localparam logic signed [33:0] FORCE_TARGET       = 34'sd65535;

    localparam logic [ADDR_W-1:0] ADDR_STOP_LIMIT     = 3'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MAG,
        ST_DIV_GRAD,
        ST_MUL_PEN,
        ST_MUL_RAMP,
        ST_DIV_PCT,
        ST_DONE
    } sesf_state_t;

endpackage

FILE: src/soft_end_stop_force.sv
// soft end stop force stage: adds a ramped spring force past the travel boundary
// past the boundary a sample goes LOAD, MAG, DIV_GRAD, MUL_PEN, MUL_RAMP, DIV_PCT, DONE; otherwise
// LOAD goes straight to DONE; only one sample is in flight, a new one is taken back in IDLE
// the serial path is two 38-step divides and two 13-step multiplies
// next sample is taken while a finished result waits in the output register
// reset (aresetn low, synchronous) clears the stop limit, ramp state and both channels
module soft_end_stop_force import sesf_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_position,
    input  logic signed [31:0] s_force_in,
    input  logic               s_disabled,
    input  logic [31:0]        s_time_ms,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_force_out,
    output logic               m_outside
);

    sesf_state_t state_reg, state_next;

    logic [LIMIT_W-1:0] tl_reg;
    logic [RAMP_W-1:0]  ramp_reg;
    logic [31:0]        next_time_reg;
    logic [BND_W-1:0]   last_bnd_reg;

    logic [31:0]        pos_reg;
    logic [31:0]        force_reg;
    logic               dis_reg;
    logic [31:0]        time_reg;
    logic [PEN_W-1:0]   pen_reg;
    logic               below_reg;
    logic               outside_reg;
    logic               term_neg_reg;
    logic [31:0]        term_reg;

    logic               m_valid_reg;
    logic [31:0]        force_out_reg;
    logic               outside_out_reg;

    logic               s_beat;
    logic               cfg_wr;

    // boundary and ramp
    logic [BND_W-1:0]   boundary;
    logic signed [31:0] bnd_diff;
    logic               bnd_drop;
    logic [RAMP_W-1:0]  ramp_base;
    logic               ramp_bump;

    // penetration
    logic signed [32:0] pos33;
    logic signed [32:0] bnd33;
    logic signed [32:0] lim33;
    logic               above;
    logic               below;
    logic               active;
    logic signed [32:0] pen_raw;
    logic [PEN_W-1:0]   pen_sel;
    logic               outside;

    // gradient magnitude
    logic signed [33:0] sum34;
    logic [33:0]        mag34;

    // serial units
    logic               div_start;
    logic [DIV_W-1:0]   div_dividend;
    logic [DVSR_W-1:0]  div_divisor;
    logic               div_done;
    logic [DIV_W-1:0]   div_q;
    logic               mul_start;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic               mul_done;
    logic [MUL_A_W-1:0] mul_p;
    logic               out_load;

    assign s_beat = s_valid && s_ready;
    assign cfg_wr = psel && penable && pwrite && pready;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_STOP_LIMIT) ? {{(32-LIMIT_W){1'b0}}, tl_reg} : '0;

    assign boundary  = {1'b0, tl_reg} + ONSET_MARGIN;
    assign bnd_diff  = $signed({1'b0, last_bnd_reg}) - $signed({1'b0, boundary});
    assign bnd_drop  = bnd_diff >= RAMP_RESET_DISTANCE;
    assign ramp_base = bnd_drop ? '0 : ramp_reg;
    assign ramp_bump = (ramp_base < RAMP_MAXIMUM) && (time_reg > next_time_reg);

    assign pos33   = $signed({pos_reg[31], pos_reg});
    assign bnd33   = $signed({2'b00, boundary});
    assign lim33   = $signed({3'b000, tl_reg});
    assign above   = pos33 > bnd33;
    assign below   = pos33 < -bnd33;
    assign active  = !dis_reg && (above || below);
    assign pen_raw = above ? (pos33 - bnd33) : (-bnd33 - pos33);
    assign pen_sel = (pen_raw > $signed({20'd0, FULL_FORCE_SPAN})) ? FULL_FORCE_SPAN
                                                                    : pen_raw[PEN_W-1:0];
    assign outside = !dis_reg && ((pos33 > lim33) || (pos33 < -lim33));

    assign sum34 = $signed({{2{force_reg[31]}}, force_reg})
                 + (below_reg ? -FORCE_TARGET : FORCE_TARGET);
    assign mag34 = sum34[33] ? 34'(-sum34) : 34'(sum34);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (s_beat) state_next = ST_LOAD;
            ST_LOAD:     state_next = active ? ST_MAG : ST_DONE;
            ST_MAG:      state_next = ST_DIV_GRAD;
            ST_DIV_GRAD: if (div_done) state_next = ST_MUL_PEN;
            ST_MUL_PEN:  if (mul_done) state_next = ST_MUL_RAMP;
            ST_MUL_RAMP: if (mul_done) state_next = ST_DIV_PCT;
            ST_DIV_PCT:  if (div_done) state_next = ST_DONE;
            ST_DONE:     if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready      = 1'b0;
        div_start    = 1'b0;
        mul_start    = 1'b0;
        out_load     = 1'b0;
        div_dividend = mul_p;
        div_divisor  = PERCENT_DIVISOR;
        mul_a        = mul_p;
        mul_b        = {{(MUL_B_W-RAMP_W){1'b0}}, ramp_reg};
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_MAG: begin
                div_start    = 1'b1;
                div_dividend = {{(DIV_W-32){1'b0}}, mag34[31:0]};
                div_divisor  = FULL_FORCE_SPAN;
            end
            ST_DIV_GRAD: begin
                mul_start = div_done;
                mul_a     = div_q;
                mul_b     = pen_reg;
            end
            ST_MUL_PEN: begin
                mul_start = mul_done;
            end
            ST_MUL_RAMP: begin
                div_start = mul_done;
            end
            ST_DONE: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: begin
            end
        endcase
    end

    sesf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    sesf_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            tl_reg        <= '0;
            ramp_reg      <= '0;
            next_time_reg <= '0;
            last_bnd_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr && (paddr == ADDR_STOP_LIMIT)) begin
                tl_reg <= pwdata[LIMIT_W-1:0];
            end
            if (state_reg == ST_LOAD) begin
                last_bnd_reg <= boundary;
                if (ramp_bump) begin
                    ramp_reg      <= ramp_base + 1'b1;
                    next_time_reg <= time_reg + RAMP_INTERVAL_MS;
                end else begin
                    ramp_reg <= ramp_base;
                end
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            pos_reg   <= s_position;
            force_reg <= s_force_in;
            dis_reg   <= s_disabled;
            time_reg  <= s_time_ms;
        end
        if (state_reg == ST_LOAD) begin
            pen_reg     <= pen_sel;
            below_reg   <= below;
            outside_reg <= outside;
            if (!active) begin
                term_reg <= '0;
            end
        end
        if (state_reg == ST_MAG) begin
            term_neg_reg <= sum34[33];
        end
        if ((state_reg == ST_DIV_PCT) && div_done) begin
            term_reg <= term_neg_reg ? 32'(-div_q[31:0]) : div_q[31:0];
        end
        if (out_load) begin
            force_out_reg   <= force_reg + term_reg;
            outside_out_reg <= outside_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_force_out = force_out_reg;
    assign m_outside   = outside_out_reg;

endmodule

FILE: src/sesf_div.sv
// bit-serial restoring divider, one quotient bit per cycle while busy
module sesf_div import sesf_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [DVSR_W-1:0] divisor,
    output logic              done,
    output logic [DIV_W-1:0]  quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     rq_reg;
    logic [DVSR_W-1:0]    rem_reg;
    logic [DVSR_W-1:0]    dvsr_reg;

    logic [DVSR_W:0]      trial;
    logic [DVSR_W:0]      diff;
    logic                 ge;
    logic [DVSR_W-1:0]    rem_next;
    logic                 last_step;

    assign trial     = {rem_reg, rq_reg[DIV_W-1]};
    assign diff      = trial - {1'b0, dvsr_reg};
    assign ge        = trial >= {1'b0, dvsr_reg};
    assign rem_next  = ge ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
    assign last_step = busy_reg && (cnt_reg == DIV_CNT_W'(DIV_W - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= last_step;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rq_reg   <= dividend;
            rem_reg  <= '0;
            dvsr_reg <= divisor;
        end else if (busy_reg) begin
            rq_reg  <= {rq_reg[DIV_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = rq_reg;

endmodule

FILE: src/sesf_mul.sv
// shift-add multiplier, one multiplier bit per cycle while busy
module sesf_mul import sesf_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [MUL_A_W-1:0] a,
    input  logic [MUL_B_W-1:0] b,
    output logic               done,
    output logic [MUL_A_W-1:0] product
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic [MUL_A_W-1:0]   acc_reg;
    logic [MUL_A_W-1:0]   a_reg;
    logic [MUL_B_W-1:0]   b_reg;
    logic                 last_step;

    assign last_step = busy_reg && (cnt_reg == MUL_CNT_W'(MUL_B_W - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= last_step;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= '0;
            a_reg   <= a;
            b_reg   <= b;
        end else if (busy_reg) begin
            acc_reg <= acc_reg + (b_reg[0] ? a_reg : '0);
            a_reg   <= {a_reg[MUL_A_W-2:0], 1'b0};
            b_reg   <= {1'b0, b_reg[MUL_B_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

FILE: src/sesf_checker.sv
// port-level checker for the soft end stop force block, bound to the top level
module sesf_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic signed [31:0] s_force_in,
    input logic               s_disabled,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_force_out,
    input logic               m_outside
);

    // no result beat survives reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_force_out) && $stable(m_outside))
        else $error("stalled result beat changed");

    // one sample in flight: no input beat right after another
    a_one_in_flight: assert property (@(posedge aclk)
        aresetn && s_valid && s_ready |=> !s_ready)
        else $error("input taken while a sample is in flight");

    // disabled sample passes force through with the outside flag low
    a_disabled_pass: assert property (@(posedge aclk)
        (aresetn && s_valid && s_ready && s_disabled && !m_valid) ##1 aresetn ##1 aresetn
        |-> ##1 (m_valid && (m_force_out == $past(s_force_in, 3)) && !m_outside))
        else $error("disabled sample not passed through");

endmodule

bind soft_end_stop_force sesf_checker u_sesf_checker (.*);
